@@ sv/kruskal_union_find_edge_filter_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the spanning-tree edge filter
// Shared shorthand for clocked properties with reset masking.
// ----------------------------------------------------------------------------
`ifndef KRUSKAL_UNION_FIND_EDGE_FILTER_UNIT_MACROS_SVH
`define KRUSKAL_UNION_FIND_EDGE_FILTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define KUFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define KUFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/kufe_pkg.sv @@
// ----------------------------------------------------------------------------
// kufe_pkg
// Shared constants, controller states and control bundles of the edge filter.
// ----------------------------------------------------------------------------
package kufe_pkg;

  // Default forest size and the fixed width of a node field.
  localparam int MaxNodesDef = 1024;
  localparam int NodeW       = 10;

  // Controller states.
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_WALK_A,
    ST_WALK_B,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // take the input item, start reading the first node
    logic sweep;     // write one entry of the clearing pass
    logic follow;    // step to the parent of the current node
    logic switch_b;  // first root found, start the second walk
    logic commit;    // second root found, decide and link
    logic emit;      // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_mode;     // mode field of the offered item
    logic in_range;    // both node indices of the offered item are in range
    logic linked;      // current node has a parent link
    logic sweep_last;  // clearing pass is at its last entry
    logic out_free;    // output register can take a result this cycle
  } status_t;

endpackage

@@ sv/kufe_ram.sv @@
// ----------------------------------------------------------------------------
// kufe_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module kufe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; a read in the write cycle returns the old data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/kufe_ctrl.sv @@
// ----------------------------------------------------------------------------
// kufe_ctrl
// Sequencer of the edge filter: clearing pass, two root walks and the result.
// ----------------------------------------------------------------------------
module kufe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  kufe_pkg::status_t status_i,
  output kufe_pkg::cmd_t    cmd_o
);

  kufe_pkg::state_e state_q, state_d;

  // State register; reset starts the clearing pass over the forest.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kufe_pkg::ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      kufe_pkg::ST_INIT: begin
        if (status_i.sweep_last) state_d = kufe_pkg::ST_IDLE;
      end
      kufe_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (!status_i.in_mode) begin
            state_d = kufe_pkg::ST_CLEAR;
          end else if (!status_i.in_range) begin
            state_d = kufe_pkg::ST_EMIT;
          end else begin
            state_d = kufe_pkg::ST_WALK_A;
          end
        end
      end
      kufe_pkg::ST_CLEAR: begin
        if (status_i.sweep_last) state_d = kufe_pkg::ST_EMIT;
      end
      kufe_pkg::ST_WALK_A: begin
        if (!status_i.linked) state_d = kufe_pkg::ST_WALK_B;
      end
      kufe_pkg::ST_WALK_B: begin
        if (!status_i.linked) state_d = kufe_pkg::ST_EMIT;
      end
      kufe_pkg::ST_EMIT: begin
        if (status_i.out_free) state_d = kufe_pkg::ST_IDLE;
      end
      default: state_d = kufe_pkg::ST_INIT;
    endcase
  end

  // Output logic.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      kufe_pkg::ST_INIT: begin
        cmd_o.sweep = 1'b1;
      end
      kufe_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      kufe_pkg::ST_CLEAR: begin
        cmd_o.sweep = 1'b1;
      end
      kufe_pkg::ST_WALK_A: begin
        cmd_o.follow   = status_i.linked;
        cmd_o.switch_b = !status_i.linked;
      end
      kufe_pkg::ST_WALK_B: begin
        cmd_o.follow = status_i.linked;
        cmd_o.commit = !status_i.linked;
      end
      kufe_pkg::ST_EMIT: begin
        cmd_o.emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

@@ sv/kufe_dp.sv @@
// ----------------------------------------------------------------------------
// kufe_dp
// Datapath of the edge filter: forest memory, walk pointer, result and
// output register.
// ----------------------------------------------------------------------------
module kufe_dp #(
  parameter int MAX_NODES = kufe_pkg::MaxNodesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       mode_i,
  input  logic [kufe_pkg::NodeW-1:0] from_node_i,
  input  logic [kufe_pkg::NodeW-1:0] to_node_i,
  input  logic                       final_edge_i,
  input  kufe_pkg::cmd_t             cmd_i,
  output kufe_pkg::status_t          status_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic                       horizontal_link_o,
  output logic                       run_done_o
);

  localparam int NW   = $clog2(MAX_NODES);
  localparam int EW   = NW + 1;
  localparam int CMPW = ((NW > kufe_pkg::NodeW) ? NW : kufe_pkg::NodeW) + 1;

  // Memory entry: link flag on top, parent index below.
  logic [EW-1:0] rdata;
  logic          mem_we;
  logic [NW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic          linked;
  logic [NW-1:0] parent;

  logic [NW-1:0] cur_q, cur_d;
  logic [NW-1:0] root_a_q;
  logic [NW-1:0] sweep_q;
  logic [kufe_pkg::NodeW-1:0] from_q, to_q;
  logic          res_acc_q, res_hor_q, res_done_q;
  logic          out_valid_q, out_acc_q, out_hor_q, out_done_q;
  logic          sweep_last;
  logic          roots_differ;
  logic          is_horizontal;

  assign linked = rdata[NW];
  assign parent = rdata[NW-1:0];

  // Status toward the controller.
  assign sweep_last = (sweep_q == NW'(MAX_NODES - 1));
  always_comb begin
    status_o.in_mode    = mode_i;
    status_o.in_range   = (CMPW'(from_node_i) < CMPW'(MAX_NODES)) &&
                          (CMPW'(to_node_i) < CMPW'(MAX_NODES));
    status_o.linked     = linked;
    status_o.sweep_last = sweep_last;
    status_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Walk pointer; the memory reads the next value so data lines up with it.
  always_comb begin
    cur_d = cur_q;
    if (cmd_i.capture) begin
      cur_d = NW'(from_node_i);
    end else if (cmd_i.follow) begin
      cur_d = parent;
    end else if (cmd_i.switch_b) begin
      cur_d = NW'(to_q);
    end
  end

  // Link decision: the larger root goes under the smaller one.
  assign roots_differ  = (cur_q != root_a_q);
  assign is_horizontal = ({1'b0, to_q} == ({1'b0, from_q} + 11'd1));

  // Memory write: clearing pass or the new link.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = '0;
    if (cmd_i.sweep) begin
      mem_we = 1'b1;
    end else if (cmd_i.commit && roots_differ) begin
      mem_we = 1'b1;
      if (cur_q > root_a_q) begin
        mem_waddr = cur_q;
        mem_wdata = {1'b1, root_a_q};
      end else begin
        mem_waddr = root_a_q;
        mem_wdata = {1'b1, cur_q};
      end
    end
  end

  kufe_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_NODES)
  ) u_forest (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(cur_d),
    .rdata_o(rdata)
  );

  // Clearing-pass counter; it wraps to zero at the end of each pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_q <= '0;
    end else if (cmd_i.sweep) begin
      sweep_q <= sweep_last ? '0 : sweep_q + NW'(1);
    end
  end

  // Item fields, walk pointer and first root.
  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (cmd_i.capture) begin
      from_q <= from_node_i;
      to_q   <= to_node_i;
    end
    if (cmd_i.switch_b) begin
      root_a_q <= cur_q;
    end
  end

  // Result of the item in work; a clear item keeps zeros, a rejected edge keeps only its final flag.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      res_acc_q  <= 1'b0;
      res_hor_q  <= 1'b0;
      res_done_q <= mode_i & final_edge_i;
    end else if (cmd_i.commit && roots_differ) begin
      res_acc_q <= 1'b1;
      res_hor_q <= is_horizontal;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_acc_q  <= res_acc_q;
      out_hor_q  <= res_hor_q;
      out_done_q <= res_done_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign horizontal_link_o = out_hor_q;
  assign run_done_o        = out_done_q;

endmodule

@@ sv/kruskal_union_find_edge_filter_unit.sv @@
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_unit
// Union-find edge filter for building a minimum spanning tree from edges
// that arrive sorted by weight.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                 Payload
//  input    in         in_valid_i / in_stall_o   mode, from_node, to_node, final_edge
//  output   out        out_valid_o / out_stall_i accepted, horizontal_link, run_done
//
//  An edge walks each of its two nodes up to the root, one forest memory
//  read per step of each parent walk; a clear item writes once per node.
//  After reset a clearing pass over every node runs with in_stall_o high.
//  The output register lets the next item start while a result waits; a
//  stalled output holds the following result back in its last state.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter_unit #(
  parameter int MAX_NODES = kufe_pkg::MaxNodesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       mode_i,
  input  logic [kufe_pkg::NodeW-1:0] from_node_i,
  input  logic [kufe_pkg::NodeW-1:0] to_node_i,
  input  logic                       final_edge_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic                       horizontal_link_o,
  output logic                       run_done_o
);

  kufe_pkg::cmd_t    cmd;
  kufe_pkg::status_t status;

  // Sequencer.
  kufe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Forest memory and result path.
  kufe_dp #(
    .MAX_NODES(MAX_NODES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .mode_i           (mode_i),
    .from_node_i      (from_node_i),
    .to_node_i        (to_node_i),
    .final_edge_i     (final_edge_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .accepted_o       (accepted_o),
    .horizontal_link_o(horizontal_link_o),
    .run_done_o       (run_done_o)
  );

endmodule

@@ sv/kufe_checker.sv @@
// ----------------------------------------------------------------------------
// kufe_checker
// Port-level checks of the edge filter, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "kruskal_union_find_edge_filter_unit_macros.svh"

module kufe_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_stall_i,
  input logic out_valid_i,
  input logic out_stall_i,
  input logic accepted_i,
  input logic horizontal_link_i,
  input logic run_done_i
);

  // A stalled result stays offered.
  `KUFE_ASSERT_NEXT(a_out_hold, out_valid_i && out_stall_i, out_valid_i, "result dropped under stall")

  // A stalled result keeps its payload.
  `KUFE_ASSERT_NEXT(a_out_stable, out_valid_i && out_stall_i, $stable(accepted_i) && $stable(horizontal_link_i) && $stable(run_done_i), "result changed under stall")

  // Only an accepted edge can be reported as a horizontal link.
  `KUFE_ASSERT_NOW(a_hor_acc, out_valid_i && horizontal_link_i, accepted_i, "horizontal link on a rejected edge")

  // Items are worked one at a time: an accept is followed by a stall.
  `KUFE_ASSERT_NEXT(a_one_item, in_valid_i && !in_stall_i, in_stall_i, "second item taken while busy")

endmodule

bind kruskal_union_find_edge_filter_unit kufe_checker u_kufe_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_i       (in_stall_o),
  .out_valid_i      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .accepted_i       (accepted_o),
  .horizontal_link_i(horizontal_link_o),
  .run_done_i       (run_done_o)
);

@@ tb/sv/kruskal_union_find_edge_filter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_unit_tb
// Self-checking bench for the spanning-tree edge filter. A shadow union-find
// forest predicts the verdict of every item. A monitor compares each result
// with the oldest prediction. Directed cases, a deep chain, an output hold-off
// and random sorted edge lists run under several idle and stall mixes.
// ----------------------------------------------------------------------------
module kruskal_union_find_edge_filter_unit_tb;

  localparam int NodeCount = kufe_pkg::MaxNodesDef;
  localparam int NodeW     = kufe_pkg::NodeW;
  localparam int ChainLen  = 128;

  // Item modes.
  localparam logic ModeClear = 1'b0;
  localparam logic ModeEdge  = 1'b1;

  typedef logic [NodeW-1:0] node_t;

  // One predicted verdict for one item.
  typedef struct packed {
    logic accepted;
    logic horizontal;
    logic run_done;
  } verdict_t;

  logic  clk       = 1'b0;
  logic  rst_n     = 1'b0;
  logic  in_valid  = 1'b0;
  logic  mode      = ModeClear;
  node_t from_node = '0;
  node_t to_node   = '0;
  logic  final_edge = 1'b0;
  logic  out_stall = 1'b0;
  logic  in_stall;
  logic  out_valid;
  logic  accepted;
  logic  horizontal_link;
  logic  run_done;

  // Shadow forest.
  int unsigned parent_of [NodeCount];
  bit          is_root   [NodeCount];

  verdict_t    pending_verdicts [$];
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_request  = 0;
  int          hold_left     = 0;
  int          err_cnt       = 0;
  int          items_sent    = 0;
  int          results_seen  = 0;
  int          joins_seen    = 0;
  int          clears_sent   = 0;

  kruskal_union_find_edge_filter_unit #(
    .MAX_NODES(NodeCount)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .mode_i           (mode),
    .from_node_i      (from_node),
    .to_node_i        (to_node),
    .final_edge_i     (final_edge),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .accepted_o       (accepted),
    .horizontal_link_o(horizontal_link),
    .run_done_o       (run_done)
  );

  // Clock generation.
  initial begin
    forever #2 clk = ~clk;
  end

  // Global time limit.
  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Makes every node of the shadow forest a root.
  function automatic void clear_forest();
    for (int i = 0; i < NodeCount; i++) begin
      parent_of[i] = 0;
      is_root[i]   = 1'b1;
    end
  endfunction

  // Follows parent links up to the root, stopping after at most NodeCount steps.
  function automatic int unsigned root_of(int unsigned n);
    int unsigned steps = 0;
    while (steps < NodeCount) begin
      if (is_root[n]) break;
      if (parent_of[n] >= NodeCount) break;
      n = parent_of[n];
      steps++;
    end
    return n;
  endfunction

  // Updates the shadow forest for one item and returns its verdict.
  function automatic verdict_t judge_item(logic m, node_t a, node_t b, logic fin);
    verdict_t    v;
    int unsigned ra;
    int unsigned rb;
    v = '0;
    if (m == ModeClear) begin
      clear_forest();
      return v;
    end
    v.run_done = fin;
    if (int'(a) >= NodeCount || int'(b) >= NodeCount) return v;
    ra = root_of(32'(a));
    rb = root_of(32'(b));
    if (ra == rb) return v;
    // The larger root goes under the smaller one.
    if (ra > rb) begin
      parent_of[ra] = rb;
      is_root[ra]   = 1'b0;
    end else begin
      parent_of[rb] = ra;
      is_root[rb]   = 1'b0;
    end
    v.accepted   = 1'b1;
    v.horizontal = (int'(b) == int'(a) + 1);
    joins_seen++;
    return v;
  endfunction

  // Offers one item and waits until it is taken. Valid stays high afterwards,
  // so the caller either sends again in the same step or releases the input.
  task automatic send_item(logic m, node_t a, node_t b, logic fin);
    int       gap = 0;
    verdict_t v;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    from_node  <= a;
    to_node    <= b;
    final_edge <= fin;
    do @(posedge clk); while (in_stall);
    v = judge_item(m, a, b, fin);
    pending_verdicts.insert(pending_verdicts.size(), v);
    items_sent++;
    if (m == ModeClear) clears_sent++;
  endtask

  // Releases the input and waits until every predicted result has arrived.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Receiver: a long hold-off when requested, random stalls otherwise.
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $error("Result item arrived with no prediction waiting");
        err_cnt++;
      end else begin
        want = pending_verdicts.pop_front();
        if (accepted !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, accepted);
          err_cnt++;
        end
        if (horizontal_link !== want.horizontal) begin
          $error("horizontal_link: expected %0b, got %0b", want.horizontal,
                 horizontal_link);
          err_cnt++;
        end
        if (run_done !== want.run_done) begin
          $error("run_done: expected %0b, got %0b", want.run_done, run_done);
          err_cnt++;
        end
      end
    end
  end

  // Corner cases: extremes, self-loops, rejections and the top-index wrap.
  task automatic test_directed_cases();
    send_item(ModeClear, 10'd1023, 10'd1023, 1'b1);
    send_item(ModeEdge,  10'd0,    10'd1,    1'b0);
    send_item(ModeEdge,  10'd1,    10'd0,    1'b0);
    send_item(ModeEdge,  10'd5,    10'd5,    1'b1);
    send_item(ModeEdge,  10'd1023, 10'd1022, 1'b0);
    send_item(ModeEdge,  10'd1022, 10'd1023, 1'b0);
    send_item(ModeEdge,  10'd1023, 10'd0,    1'b0);
    send_item(ModeEdge,  10'd512,  10'd511,  1'b0);
    send_item(ModeEdge,  10'd511,  10'd512,  1'b0);
    send_item(ModeEdge,  10'd0,    10'd1023, 1'b0);
    send_item(ModeEdge,  10'd682,  10'd341,  1'b0);
    send_item(ModeEdge,  10'd341,  10'd342,  1'b1);
    send_item(ModeClear, 10'd0,    10'd0,    1'b0);
    // After a clear the top node wraps to zero without counting as horizontal.
    send_item(ModeEdge,  10'd1023, 10'd0,    1'b0);
    send_item(ModeEdge,  10'd0,    10'd1023, 1'b1);
    drain_results();
  endtask

  // Builds one long chain at the top of the index range, then walks it.
  task automatic test_deep_chain();
    node_t base;
    base = node_t'(NodeCount - ChainLen);
    send_item(ModeClear, '0, '0, 1'b0);
    for (int i = ChainLen - 1; i >= 1; i--) begin
      send_item(ModeEdge, base + node_t'(i - 1), base + node_t'(i), 1'b0);
    end
    send_item(ModeEdge, 10'd1023, 10'd1023, 1'b0);
    send_item(ModeEdge, 10'd1023, base, 1'b0);
    send_item(ModeEdge, 10'd1023, 10'd0, 1'b1);
    drain_results();
  endtask

  // The receiver holds off while edges keep coming, so the block backs up.
  // The clear runs to completion first so the hold-off meets the edges.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_item(ModeClear, '0, '0, 1'b0);
    drain_results();
    hold_request = 400;
    for (int i = 0; i < 12; i++) begin
      send_item(ModeEdge, node_t'($urandom_range(31)), node_t'($urandom_range(31)),
                (i == 11));
    end
    drain_results();
  endtask

  // Random sorted edge lists: mostly edges inside a small window of nodes,
  // each list opened by a clear and mostly closed by a final edge, plus noise.
  task automatic test_random_edges(int n_items, int idle_pct, int stall_mix);
    int    left_in_list = 0;
    int    span         = 16;
    node_t base         = '0;
    node_t a;
    node_t b;
    int    pick;
    send_idle_pct = idle_pct;
    stall_pct     = stall_mix;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      if (left_in_list == 0) begin
        // Open a new list.
        left_in_list = $urandom_range(40, 8);
        span         = ($urandom_range(3) == 0) ? 64 : 16;
        base         = node_t'($urandom);
        send_item(ModeClear, node_t'($urandom), node_t'($urandom), 1'(($urandom)));
      end else if (pick < 3) begin
        // Stray clear in the middle of a list.
        send_item(ModeClear, node_t'($urandom), node_t'($urandom), 1'(($urandom)));
      end else if (pick < 12) begin
        // Edge anywhere in the index range.
        send_item(ModeEdge, node_t'($urandom), node_t'($urandom), 1'(($urandom)));
        left_in_list--;
      end else begin
        a = base + node_t'($urandom_range(span - 1));
        b = ($urandom_range(99) < 30) ? a + 1'b1 : base + node_t'($urandom_range(span - 1));
        left_in_list--;
        send_item(ModeEdge, a, b, (left_in_list == 0));
      end
    end
    drain_results();
  endtask

  // Test sequence.
  initial begin
    clear_forest();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_deep_chain();
    test_output_backpressure();
    test_random_edges(60, 0, 0);
    test_random_edges(60, 49, 0);
    test_random_edges(60, 0, 49);
    test_random_edges(60, 22, 22);

    stall_pct = 0;
    repeat (64) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d predicted results never arrived", pending_verdicts.size());
      err_cnt++;
    end

    $display("Sent %0d items (%0d clears); %0d results checked, %0d edges joined trees.",
             items_sent, clears_sent, results_seen, joins_seen);
    $display("Covered corner edges, a %0d-node chain, output hold-off and four idle mixes.",
             ChainLen);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
